// ===== rtl/core/btpc_pkg.sv =====
package btpc_pkg;

    // Fixed constants of the compensation scheme
    localparam logic [31:0] C_PRESS_OFFSET = 32'd128000;
    localparam logic [20:0] C_ADC_FULL     = 21'd1048576;
    localparam logic [11:0] C_NUM_SCALE    = 12'd3125;
    localparam logic [39:0] C_TEMP_ROUND   = 40'd128;
    localparam logic [39:0] C_TEMP_SCALE   = 40'd5;

    // Pipeline geometry: 11 front stages, one divider stage per quotient bit, 5 back stages
    localparam int DIV_STAGES = 64;
    localparam int FRONT_LAT  = 11;
    localparam int P_LAT      = FRONT_LAT + DIV_STAGES + 5;

    // Configuration register index
    typedef enum logic [1:0] {
        REG_TEMP_CAL   = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_MID  = 2'd2,
        REG_PRESS_HIGH = 2'd3
    } t_reg_idx;

    // Low 64 bits of a times sign-extended 16-bit b
    function automatic logic [63:0] f_mul_s16(input logic [63:0] a, input logic [15:0] b);
        logic [79:0] v_prod;
        v_prod = {16'b0, a} * {64'b0, b};
        return v_prod[63:0] - (b[15] ? {a[47:0], 16'b0} : 64'b0);
    endfunction

    // Low 64 bits of a times unsigned 16-bit b
    function automatic logic [63:0] f_mul_u16(input logic [63:0] a, input logic [15:0] b);
        logic [79:0] v_prod;
        v_prod = {16'b0, a} * {64'b0, b};
        return v_prod[63:0];
    endfunction

    // Arithmetic right shift of a 64-bit word
    function automatic logic [63:0] f_asr(input logic [63:0] a, input logic [5:0] n);
        return 64'($signed(a) >>> n);
    endfunction

endpackage

// ===== rtl/core/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation, 64-bit integer scheme.
//
// Input channel: i_valid / o_stall carry one word of raw pressure and raw
// temperature (20 bits each). Output channel: o_valid / i_stall carry one
// word of temperature in 0.01 degC, pressure in Pa as Q24.8 and a flag set
// when the pressure divisor was zero (pressure then reads 0). pready is
// always high. Calibration words are written over APB at byte addresses
// 0, 8, 16, 24, by the user only while the block is idle (not enforced).
//
// Pipeline: 11 arithmetic stages, a 64-stage restoring divider that
// retires one quotient bit per stage, and 5 stages of final terms.
// Throughput is one word per cycle while the output word is not stalled.
// All stages move together: while the output word is held by i_stall the
// whole pipeline freezes and o_stall is raised; nothing is lost or repeated.
// Synchronous reset clears all valid bits and the calibration registers.
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_divisor_zero,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [47:0] r_temp_cal;
    logic [63:0] r_press_low;
    logic [63:0] r_press_mid;
    logic [15:0] r_press_high;
    t_reg_idx    w_idx;

    assign w_idx  = t_reg_idx'(paddr[4:3]);
    assign pready = 1'b1;

    // Write calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal   <= '0;
            r_press_low  <= '0;
            r_press_mid  <= '0;
            r_press_high <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_TEMP_CAL:   r_temp_cal   <= pwdata[47:0];
                REG_PRESS_LOW:  r_press_low  <= pwdata;
                REG_PRESS_MID:  r_press_mid  <= pwdata;
                REG_PRESS_HIGH: r_press_high <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_TEMP_CAL:   prdata = {16'b0, r_temp_cal};
            REG_PRESS_LOW:  prdata = r_press_low;
            REG_PRESS_MID:  prdata = r_press_mid;
            REG_PRESS_HIGH: prdata = {48'b0, r_press_high};
            default:        prdata = '0;
        endcase
    end

    // Calibration words
    logic [15:0] w_t1, w_t2, w_t3, w_p1, w_p2, w_p3, w_p4;
    logic [15:0] w_p5, w_p6, w_p7, w_p8, w_p9;
    assign w_t1 = r_temp_cal[15:0];
    assign w_t2 = r_temp_cal[31:16];
    assign w_t3 = r_temp_cal[47:32];
    assign w_p1 = r_press_low[15:0];
    assign w_p2 = r_press_low[31:16];
    assign w_p3 = r_press_low[47:32];
    assign w_p4 = r_press_low[63:48];
    assign w_p5 = r_press_mid[15:0];
    assign w_p6 = r_press_mid[31:16];
    assign w_p7 = r_press_mid[47:32];
    assign w_p8 = r_press_mid[63:48];
    assign w_p9 = r_press_high;

    // Global advance: hold everything while the output word is stalled
    logic             w_en;
    logic [P_LAT-1:0] r_vld;
    assign w_en    = !(r_vld[P_LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[P_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[P_LAT-2:0], i_valid};
        end
    end

    // ---------------- front stages ----------------
    logic signed [18:0] r_a;
    logic signed [17:0] r_b;
    logic [20:0]        r_pin [1:8];
    logic signed [23:0] r_v1_2, r_v1_3;
    logic signed [35:0] r_bb;
    logic signed [39:0] r_m3;
    logic signed [31:0] r_tfine;
    logic signed [31:0] r_q1;
    logic [15:0]        r_tcs [5:10];
    logic [63:0]        r_qq, r_q1p5_6, r_q1p2_6, r_q1p5_7, r_q1p2_7, r_t6, r_t3m;
    logic [63:0]        r_q2, r_q1b, r_x, r_num0, r_num;
    logic signed [30:0] r_d;
    logic               r_z10;

    logic signed [34:0] w_pa;
    logic signed [39:0] w_t5;
    logic signed [31:0] w_tcs;
    logic [15:0]        w_tc;

    assign w_pa  = 35'(r_a) * 35'($signed(w_t2));
    assign w_t5  = 40'(r_tfine) * $signed(C_TEMP_SCALE) + $signed(C_TEMP_ROUND);
    assign w_tcs = 32'(w_t5 >>> 8);
    assign w_tc  = (w_tcs > 32'sd32767)  ? 16'h7FFF :
                   (w_tcs < -32'sd32768) ? 16'h8000 : w_tcs[15:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // S1: offset raw temperature, form pressure complement
            r_a      <= $signed({2'b0, i_raw_temperature[19:3]}) - $signed({2'b0, w_t1, 1'b0});
            r_b      <= $signed({2'b0, i_raw_temperature[19:4]}) - $signed({2'b0, w_t1});
            r_pin[1] <= C_ADC_FULL - {1'b0, i_raw_pressure};
            for (int k = 2; k <= 8; k++) r_pin[k] <= r_pin[k-1];
            // S2: first temperature term, square of offset
            r_v1_2   <= 24'(w_pa >>> 11);
            r_bb     <= 36'(r_b) * 36'(r_b);
            // S3: second temperature product
            r_m3     <= 40'(r_bb >>> 12) * 40'($signed(w_t3));
            r_v1_3   <= r_v1_2;
            // S4: fine temperature
            r_tfine  <= 32'(r_v1_3) + 32'(r_m3 >>> 14);
            // S5: temperature output and pressure offset
            r_tcs[5] <= w_tc;
            for (int k = 6; k <= 10; k++) r_tcs[k] <= r_tcs[k-1];
            r_q1     <= r_tfine - $signed(C_PRESS_OFFSET);
            // S6: products of the offset
            r_qq     <= 64'(64'(r_q1) * 64'(r_q1));
            r_q1p5_6 <= 64'(64'(r_q1) * 64'($signed(w_p5)));
            r_q1p2_6 <= 64'(64'(r_q1) * 64'($signed(w_p2)));
            // S7: square terms with calibration words
            r_t6     <= f_mul_s16(r_qq, w_p6);
            r_t3m    <= f_mul_s16(r_qq, w_p3);
            r_q1p5_7 <= r_q1p5_6;
            r_q1p2_7 <= r_q1p2_6;
            // S8: sum pressure partials
            r_q2     <= r_t6 + {r_q1p5_7[46:0], 17'b0}
                        + {{13{w_p4[15]}}, w_p4, 35'b0};
            r_q1b    <= f_asr(r_t3m, 6'd8) + {r_q1p2_7[51:0], 12'b0};
            // S9: divisor product, dividend base
            r_x      <= f_mul_u16(64'h0000_8000_0000_0000 + r_q1b, w_p1);
            r_num0   <= {r_pin[8][20:0], 31'b0} - r_q2;
            // S10: divisor, scaled dividend
            r_d      <= $signed(r_x[63:33]);
            r_z10    <= (r_x[63:33] == 31'd0);
            r_num    <= 64'({12'b0, r_num0} * {64'b0, C_NUM_SCALE});
        end
    end

    // ---------------- divider ----------------
    logic [30:0] r_dv_r [0:DIV_STAGES];
    logic [63:0] r_dv_n [0:DIV_STAGES];
    logic [30:0] r_dv_m [0:DIV_STAGES];
    logic [15:0] r_dv_t [0:DIV_STAGES];
    logic        r_dv_z [0:DIV_STAGES];
    logic        r_dv_s [0:DIV_STAGES];

    // S11: take magnitudes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_r[0] <= '0;
            r_dv_n[0] <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_dv_m[0] <= r_d[30] ? 31'(-r_d) : 31'(r_d);
            r_dv_s[0] <= r_num[63] ^ r_d[30];
            r_dv_t[0] <= r_tcs[10];
            r_dv_z[0] <= r_z10;
        end
    end

    // One quotient bit per stage
    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        logic [31:0] w_trial;
        logic [31:0] w_diff;
        logic        w_ge;
        assign w_trial = {r_dv_r[g-1], r_dv_n[g-1][63]};
        assign w_diff  = w_trial - {1'b0, r_dv_m[g-1]};
        assign w_ge    = (w_trial >= {1'b0, r_dv_m[g-1]});
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_r[g] <= w_ge ? w_diff[30:0] : w_trial[30:0];
                r_dv_n[g] <= {r_dv_n[g-1][62:0], w_ge};
                r_dv_m[g] <= r_dv_m[g-1];
                r_dv_s[g] <= r_dv_s[g-1];
                r_dv_t[g] <= r_dv_t[g-1];
                r_dv_z[g] <= r_dv_z[g-1];
            end
        end
    end

    // ---------------- back stages ----------------
    logic [63:0] r_p [1:4];
    logic [15:0] r_tcp [1:4];
    logic        r_zp [1:4];
    logic [63:0] r_ll, r_r2m, r_sq, r_r2_3, r_r2_4, r_r1m;
    logic [30:0] r_lh;
    logic [63:0] w_ps, w_r;
    logic [30:0] w_lh;
    logic [15:0] r_tc_o;
    logic [31:0] r_pr_o;
    logic        r_z_o;

    assign w_ps = f_asr(r_p[1], 6'd13);
    assign w_lh = 31'(w_ps[31:0] * w_ps[63:32]);
    assign w_r  = f_asr(r_p[4] + f_asr(r_r1m, 6'd25) + r_r2_4, 6'd8)
                  + {{44{w_p7[15]}}, w_p7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // P1: apply quotient sign
            r_p[1]   <= r_dv_s[DIV_STAGES] ? (64'd0 - r_dv_n[DIV_STAGES]) : r_dv_n[DIV_STAGES];
            r_tcp[1] <= r_dv_t[DIV_STAGES];
            r_zp[1]  <= r_dv_z[DIV_STAGES];
            for (int k = 2; k <= 4; k++) begin
                r_p[k]   <= r_p[k-1];
                r_tcp[k] <= r_tcp[k-1];
                r_zp[k]  <= r_zp[k-1];
            end
            // P2: partial squares of the shifted quotient, P8 term
            r_ll     <= w_ps[31:0] * w_ps[31:0];
            r_lh     <= w_lh;
            r_r2m    <= f_mul_s16(r_p[1], w_p8);
            // P3: assemble square
            r_sq     <= r_ll + {r_lh, 33'b0};
            r_r2_3   <= f_asr(r_r2m, 6'd19);
            // P4: P9 term
            r_r1m    <= f_mul_s16(r_sq, w_p9);
            r_r2_4   <= r_r2_3;
            // P5: final sum, saturate
            r_tc_o   <= r_tcp[4];
            r_z_o    <= r_zp[4];
            if (r_zp[4] || w_r[63])       r_pr_o <= '0;
            else if (w_r[63:32] != 32'd0) r_pr_o <= 32'hFFFF_FFFF;
            else                          r_pr_o <= w_r[31:0];
        end
    end

    assign o_temperature_centi = $signed(r_tc_o);
    assign o_pressure_q24_8    = r_pr_o;
    assign o_divisor_zero      = r_z_o;

endmodule

// ===== rtl/core/btpc_checker.sv =====
module btpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_temperature_centi,
    input logic [31:0] o_pressure_q24_8,
    input logic        o_divisor_zero
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pressure_q24_8)
        && $stable(o_temperature_centi) && $stable(o_divisor_zero))
        else $error("stalled output word changed");

    // Back pressure only while the output word waits
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without held output");

    // Zero divisor forces pressure to zero
    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divisor_zero |-> o_pressure_q24_8 == 32'd0)
        else $error("pressure nonzero with zero divisor");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_temperature_centi (o_temperature_centi),
    .o_pressure_q24_8    (o_pressure_q24_8),
    .o_divisor_zero      (o_divisor_zero)
);
